/* design/orr_pkg.sv */
// ----------------------------------------------------------------------------
// orr_pkg
// Shared constants, command codes and transaction types for the record ring.
// ----------------------------------------------------------------------------
package orr_pkg;

    localparam int RING_DEPTH   = 1024;
    localparam int HANDLE_WIDTH = 32;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int OCC_W = $clog2(RING_DEPTH + 1);
    // stored handle bits: the port field is 32 bits wide
    localparam int HW    = (HANDLE_WIDTH < 32) ? HANDLE_WIDTH : 32;
    localparam int STAMP_W = 64;
    localparam int RAM_W = STAMP_W + HW;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_TAKE  = 2'd1;
    localparam logic [1:0] CMD_DROPS = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] record_handle;
        logic [63:0] since_mark;
    } t_in;

    typedef struct packed {
        logic        handle_valid;
        logic [31:0] out_handle;
        logic [63:0] drop_count;
        logic [63:0] enqueued_total;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_EVICT = 4'b0100,
        S_TAKE  = 4'b1000
    } t_state;

endpackage

/* design/orr_ram.sv */
// ----------------------------------------------------------------------------
// orr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module orr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/overwriting_record_ring_with_marks.sv */
// ----------------------------------------------------------------------------
// overwriting_record_ring_with_marks
// Overwriting ring of record handles stamped with sequence numbers.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. i_item carries
// the command, the handle to push and the mark for a take. Exactly one result
// follows each transaction on o_result, marked by o_strobe for one cycle; the
// receiver has no way to hold it off and must take it then.
// Entries (handle and stamp) live in one synchronous RAM with a registered
// read port; head, occupancy, drop count and sequence counter sit in
// flip-flops.
// After accept the command is registered, then executed: a zero push, a
// non-full push, a drop read, an unused command or a take on an empty ring
// finish in the execute state; an evicting push reads the oldest entry there,
// then overwrites its slot in the evict state; a take reads one entry per
// cycle while stale entries are skipped. busy drops in the strobe cycle, so a new start can be taken there.
// Reset clears head, occupancy, counters and control; the RAM is not cleared
// since only pushed slots are ever read.
// ----------------------------------------------------------------------------
module overwriting_record_ring_with_marks (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  orr_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_strobe,
    output orr_pkg::t_out o_result
);

    orr_pkg::t_state r_state, n_state;
    orr_pkg::t_in    r_req, n_req;
    logic [orr_pkg::IDX_W-1:0] r_head, n_head;
    logic [orr_pkg::OCC_W-1:0] r_occ, n_occ;
    logic [63:0] r_drops, n_drops;
    logic [63:0] r_seq, n_seq;
    orr_pkg::t_out r_res, n_res;
    logic r_strobe, n_strobe;

    logic                      ram_we, ram_re;
    logic [orr_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
    logic [orr_pkg::RAM_W-1:0] ram_wdata, ram_rdata;

    logic [orr_pkg::IDX_W-1:0] head_next;
    logic [orr_pkg::IDX_W:0]   tail_sum;
    logic [orr_pkg::IDX_W-1:0] tail_slot;
    logic                      full;
    logic [orr_pkg::HW-1:0]    push_handle;
    logic [orr_pkg::HW-1:0]    rd_handle;
    logic [63:0]               rd_stamp;

    orr_ram #(
        .WIDTH (orr_pkg::RAM_W),
        .DEPTH (orr_pkg::RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign head_next = (r_head == orr_pkg::IDX_W'(orr_pkg::RING_DEPTH - 1))
                     ? '0 : r_head + 1'b1;
    assign tail_sum  = {1'b0, r_head} + (orr_pkg::IDX_W + 1)'(r_occ);
    assign tail_slot = (tail_sum >= (orr_pkg::IDX_W + 1)'(orr_pkg::RING_DEPTH))
                     ? orr_pkg::IDX_W'(tail_sum - (orr_pkg::IDX_W + 1)'(orr_pkg::RING_DEPTH))
                     : tail_sum[orr_pkg::IDX_W-1:0];
    assign full        = (r_occ == orr_pkg::OCC_W'(orr_pkg::RING_DEPTH));
    assign push_handle = r_req.record_handle[orr_pkg::HW-1:0];
    assign rd_handle   = ram_rdata[orr_pkg::HW-1:0];
    assign rd_stamp    = ram_rdata[orr_pkg::RAM_W-1:orr_pkg::HW];

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_head    = r_head;
        n_occ     = r_occ;
        n_drops   = r_drops;
        n_seq     = r_seq;
        n_res     = r_res;
        n_strobe  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = tail_slot;
        ram_wdata = {r_seq, push_handle};
        ram_re    = 1'b0;
        ram_raddr = r_head;

        unique case (r_state)
            orr_pkg::S_IDLE: begin
                if (start) begin
                    n_req   = i_item;
                    n_state = orr_pkg::S_EXEC;
                end
            end
            orr_pkg::S_EXEC: begin
                n_res = '0;
                case (r_req.cmd)
                    orr_pkg::CMD_PUSH: begin
                        if (push_handle == '0) begin
                            n_res.enqueued_total = r_seq;
                            n_strobe             = 1'b1;
                            n_state              = orr_pkg::S_IDLE;
                        end else if (full) begin
                            // fetch the oldest entry before overwriting its slot
                            ram_re  = 1'b1;
                            n_state = orr_pkg::S_EVICT;
                        end else begin
                            ram_we               = 1'b1;
                            n_seq                = r_seq + 64'd1;
                            n_occ                = r_occ + 1'b1;
                            n_res.enqueued_total = n_seq;
                            n_strobe             = 1'b1;
                            n_state              = orr_pkg::S_IDLE;
                        end
                    end
                    orr_pkg::CMD_TAKE: begin
                        if (r_occ == '0) begin
                            n_res.enqueued_total = r_seq;
                            n_strobe             = 1'b1;
                            n_state              = orr_pkg::S_IDLE;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = orr_pkg::S_TAKE;
                        end
                    end
                    orr_pkg::CMD_DROPS: begin
                        n_res.drop_count     = r_drops;
                        n_res.enqueued_total = r_seq;
                        n_drops              = '0;
                        n_strobe             = 1'b1;
                        n_state              = orr_pkg::S_IDLE;
                    end
                    default: begin
                        n_res.enqueued_total = r_seq;
                        n_strobe             = 1'b1;
                        n_state              = orr_pkg::S_IDLE;
                    end
                endcase
            end
            orr_pkg::S_EVICT: begin
                // full ring: the new record lands in the old head slot
                ram_we               = 1'b1;
                ram_waddr            = r_head;
                n_head               = head_next;
                n_drops              = r_drops + 64'd1;
                n_seq                = r_seq + 64'd1;
                n_res                = '0;
                n_res.handle_valid   = 1'b1;
                n_res.out_handle     = 32'(rd_handle);
                n_res.enqueued_total = n_seq;
                n_strobe             = 1'b1;
                n_state              = orr_pkg::S_IDLE;
            end
            orr_pkg::S_TAKE: begin
                n_head = head_next;
                n_occ  = r_occ - 1'b1;
                n_res  = '0;
                n_res.enqueued_total = r_seq;
                if (rd_stamp >= r_req.since_mark) begin
                    n_res.handle_valid = 1'b1;
                    n_res.out_handle   = 32'(rd_handle);
                    n_strobe           = 1'b1;
                    n_state            = orr_pkg::S_IDLE;
                end else if (n_occ == '0) begin
                    n_strobe = 1'b1;
                    n_state  = orr_pkg::S_IDLE;
                end else begin
                    // stale entry dropped, look at the next one
                    ram_re    = 1'b1;
                    ram_raddr = head_next;
                end
            end
            default: begin
                n_state = orr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= orr_pkg::S_IDLE;
            r_head   <= '0;
            r_occ    <= '0;
            r_drops  <= '0;
            r_seq    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_occ    <= n_occ;
            r_drops  <= n_drops;
            r_seq    <= n_seq;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_res <= n_res;
    end

    assign busy     = (r_state != orr_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

/* design/orr_checker.sv */
// ----------------------------------------------------------------------------
// orr_checker
// Port-level checks on transaction sequencing of the record ring.
// ----------------------------------------------------------------------------
module orr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input orr_pkg::t_out o_result
);

    // an accepted transaction always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while still busy");

    // a result strobe is never directly followed by another
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe on consecutive cycles");

    a_strobe_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    a_no_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.handle_valid) |-> (o_result.out_handle == '0))
        else $error("handle reported without handle_valid");

endmodule

bind overwriting_record_ring_with_marks orr_checker u_orr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the overwriting record ring with sequence marks.
// A short table of directed commands comes first, then random pushes, takes,
// drop reads and unused commands that fill the ring, push it into eviction
// and walk past stale entries. Typed rows are checked against their table
// result, every other result against a cycle-free ring model in the bench.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RAND_ITEMS   = 1400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_SHOWN    = 10;
    localparam int DIR_ROWS     = 21;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [31:0]   handle;
        logic [63:0]   mark;
        logic          typed;
        orr_pkg::t_out want;
    } t_dir_row;

    // typed rows carry their result; the rest go through the ring model
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{orr_pkg::CMD_TAKE, 32'h0, 64'h0, 1'b1, '{1'b0, 32'h0, 64'd0, 64'd0}},
        '{orr_pkg::CMD_DROPS, 32'h0, 64'h0, 1'b1, '{1'b0, 32'h0, 64'd0, 64'd0}},
        '{CMD_UNUSED, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1,
          '{1'b0, 32'h0, 64'd0, 64'd0}},
        '{orr_pkg::CMD_PUSH, 32'h0, 64'hFFFFFFFFFFFFFFFF, 1'b1,
          '{1'b0, 32'h0, 64'd0, 64'd0}},
        '{orr_pkg::CMD_PUSH, 32'hFFFFFFFF, 64'h0, 1'b1, '{1'b0, 32'h0, 64'd0, 64'd1}},
        '{orr_pkg::CMD_PUSH, 32'h00000001, 64'h0, 1'b1, '{1'b0, 32'h0, 64'd0, 64'd2}},
        '{orr_pkg::CMD_PUSH, 32'h80000000, 64'h0, 1'b1, '{1'b0, 32'h0, 64'd0, 64'd3}},
        '{orr_pkg::CMD_TAKE, 32'h0, 64'h0, 1'b1,
          '{1'b1, 32'hFFFFFFFF, 64'd0, 64'd3}},
        '{orr_pkg::CMD_TAKE, 32'h0, 64'd2, 1'b1,
          '{1'b1, 32'h80000000, 64'd0, 64'd3}},
        '{orr_pkg::CMD_TAKE, 32'h0, 64'h0, 1'b1, '{1'b0, 32'h0, 64'd0, 64'd3}},
        '{orr_pkg::CMD_PUSH, 32'hA5A5A5A5, 64'h0, 1'b1, '{1'b0, 32'h0, 64'd0, 64'd4}},
        '{orr_pkg::CMD_PUSH, 32'h5A5A5A5A, 64'h0, 1'b1, '{1'b0, 32'h0, 64'd0, 64'd5}},
        '{orr_pkg::CMD_TAKE, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1,
          '{1'b0, 32'h0, 64'd0, 64'd5}},
        '{orr_pkg::CMD_PUSH, 32'h12345678, 64'h0, 1'b1, '{1'b0, 32'h0, 64'd0, 64'd6}},
        '{orr_pkg::CMD_TAKE, 32'h0, 64'd5, 1'b1,
          '{1'b1, 32'h12345678, 64'd0, 64'd6}},
        '{orr_pkg::CMD_PUSH, 32'h0000FFFF, 64'h0, 1'b0, '0},
        '{orr_pkg::CMD_PUSH, 32'hFFFF0000, 64'h0, 1'b0, '0},
        '{orr_pkg::CMD_TAKE, 32'h0, 64'd7, 1'b0, '0},
        '{orr_pkg::CMD_DROPS, 32'h0, 64'h0, 1'b0, '0},
        '{CMD_UNUSED, 32'h5A5A5A5A, 64'h0123456789ABCDEF, 1'b0, '0},
        '{orr_pkg::CMD_TAKE, 32'h0, 64'h8000000000000000, 1'b0, '0}
    };

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    orr_pkg::t_in  i_item;
    logic          busy;
    logic          o_strobe;
    orr_pkg::t_out o_result;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    overwriting_record_ring_with_marks dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // ring model
    logic [31:0] ring_handle [orr_pkg::RING_DEPTH];
    logic [63:0] ring_stamp [orr_pkg::RING_DEPTH];
    int unsigned ring_head = 0;
    int unsigned ring_occ = 0;
    logic [63:0] ring_drops = '0;
    logic [63:0] ring_seq = '0;
    bit          ring_was_full = 1'b0;

    orr_pkg::t_out expected_q [$];
    int unsigned   mismatches = 0;
    int unsigned   stall_cycles = 0;
    int unsigned   idle_pct = 6;

    function automatic orr_pkg::t_out ring_step(input orr_pkg::t_in it);
        orr_pkg::t_out r;
        logic [31:0]   h;
        int unsigned   slot;
        bit            found;
        r = '0;
        h = it.record_handle & 32'((64'd1 << orr_pkg::HW) - 64'd1);
        case (it.cmd)
            orr_pkg::CMD_PUSH: begin
                if (h != '0) begin
                    if (ring_occ == orr_pkg::RING_DEPTH) begin
                        r.handle_valid = 1'b1;
                        r.out_handle = ring_handle[ring_head];
                        ring_head = (ring_head + 1) % orr_pkg::RING_DEPTH;
                        ring_occ--;
                        ring_drops++;
                    end
                    slot = (ring_head + ring_occ) % orr_pkg::RING_DEPTH;
                    ring_handle[slot] = h;
                    ring_stamp[slot] = ring_seq;
                    ring_seq++;
                    ring_occ++;
                    if (ring_occ == orr_pkg::RING_DEPTH) ring_was_full = 1'b1;
                end
            end
            orr_pkg::CMD_TAKE: begin
                found = 1'b0;
                while (ring_occ > 0 && !found) begin
                    slot = ring_head;
                    ring_head = (ring_head + 1) % orr_pkg::RING_DEPTH;
                    ring_occ--;
                    if (ring_stamp[slot] >= it.since_mark) begin
                        found = 1'b1;
                        r.handle_valid = 1'b1;
                        r.out_handle = ring_handle[slot];
                    end
                end
            end
            orr_pkg::CMD_DROPS: begin
                r.drop_count = ring_drops;
                ring_drops = '0;
            end
            default: ;
        endcase
        r.enqueued_total = ring_seq;
        return r;
    endfunction

    // push-heavy until the ring has been full once, then a mix that keeps it deep
    function automatic orr_pkg::t_in next_ring_item();
        orr_pkg::t_in it;
        int unsigned  pick;
        int unsigned  sel;
        logic [63:0]  oldest;
        it.cmd = orr_pkg::CMD_PUSH;
        it.record_handle = $urandom;
        it.since_mark = {$urandom, $urandom};
        if ($urandom_range(99) < 3) it.record_handle = '0;
        oldest = ring_seq - 64'(ring_occ);
        pick = $urandom_range(99);
        if (!ring_was_full) begin
            if (pick >= 99) it.cmd = CMD_UNUSED;
            else if (pick >= 97) it.cmd = orr_pkg::CMD_DROPS;
            else if (pick >= 95) it.cmd = orr_pkg::CMD_TAKE;
        end else begin
            if (pick >= 92) it.cmd = CMD_UNUSED;
            else if (pick >= 84) it.cmd = orr_pkg::CMD_DROPS;
            else if (pick >= 68) it.cmd = orr_pkg::CMD_TAKE;
        end
        if (it.cmd == orr_pkg::CMD_TAKE) begin
            sel = $urandom_range(99);
            // while filling, a take removes only the oldest entry
            if (!ring_was_full || sel < 25) it.since_mark = '0;
            else if (sel < 50) it.since_mark = oldest;
            else if (sel < 80) it.since_mark = oldest + 64'($urandom_range(0, 8));
            else if (sel < 96) it.since_mark = ring_seq - 64'($urandom_range(0, ring_occ));
            else if (sel < 98) it.since_mark = ring_seq + 64'($urandom_range(0, 3));
        end
        return it;
    endfunction

    task automatic send_item(input orr_pkg::t_in it, input bit typed,
                             input orr_pkg::t_out want);
        orr_pkg::t_out pred;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pred = ring_step(it);
        expected_q.push_back(typed ? want : pred);
    endtask

    initial begin
        orr_pkg::t_in it;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            it.cmd = DIR_TAB[k].cmd;
            it.record_handle = DIR_TAB[k].handle;
            it.since_mark = DIR_TAB[k].mark;
            send_item(it, DIR_TAB[k].typed, DIR_TAB[k].want);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n < RAND_ITEMS / 3) idle_pct = 6;
            else if (n < 2 * RAND_ITEMS / 3) idle_pct = 63;
            else idle_pct = 0;
            it = next_ring_item();
            send_item(it, 1'b0, '0);
        end
        start <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        orr_pkg::t_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_q.size() == 0) begin
                if (mismatches < MAX_SHOWN)
                    $display("unexpected result: valid %0b handle %h drops %0d total %0d",
                             o_result.handle_valid, o_result.out_handle,
                             o_result.drop_count, o_result.enqueued_total);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                if (o_result.handle_valid !== want.handle_valid ||
                    o_result.out_handle !== want.out_handle ||
                    o_result.drop_count !== want.drop_count ||
                    o_result.enqueued_total !== want.enqueued_total) begin
                    if (mismatches < MAX_SHOWN) begin
                        $display("result mismatch: expected valid %0b handle %h drops %0d total %0d",
                                 want.handle_valid, want.out_handle,
                                 want.drop_count, want.enqueued_total);
                        $display("                 actual   valid %0b handle %h drops %0d total %0d",
                                 o_result.handle_valid, o_result.out_handle,
                                 o_result.drop_count, o_result.enqueued_total);
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog: a take walking a full ring of stale entries is the longest quiet stretch
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
